>>> rtl/i2cmbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cmbe_pkg;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL_TICKS = 1'b1;

	localparam logic [7:0] PHASE_TICKS_RST     = 8'd5;
	localparam logic [7:0] READ_TAIL_TICKS_RST = 8'd3;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ST_HIGH = 4'd1,
		PH_ST_LOW  = 4'd2,
		PH_SP_CLK  = 4'd3,
		PH_SP_DAT  = 4'd4,
		PH_WR_DATA = 4'd5,
		PH_WR_HIGH = 4'd6,
		PH_WR_LOW  = 4'd7,
		PH_WR_REL  = 4'd8,
		PH_WR_ACKH = 4'd9,
		PH_RD_HIGH = 4'd10,
		PH_RD_LOW  = 4'd11,
		PH_RD_ACKS = 4'd12,
		PH_RD_ACKH = 4'd13,
		PH_RD_TAIL = 4'd14
	} phase_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic       ack_level;
		logic       sda_sense;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       slave_ack_low;
		logic       command_dropped;
	} out_item_t;

	// classified tick as it sits in the queue
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
		logic       ack_level;
		logic       sda_sense;
	} tick_t;

endpackage

`default_nettype wire

>>> rtl/i2cmbe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cmbe_front #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  i2cmbe_pkg::in_item_t in_item,
	output logic                 q_valid,
	output i2cmbe_pkg::tick_t    q_tick,
	input  wire                  q_pop
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	i2cmbe_pkg::tick_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	i2cmbe_pkg::tick_t cls_tick;
	logic              push;
	logic              pop;

	always_comb begin
		cls_tick.data_byte = in_item.data_byte;
		cls_tick.ack_level = in_item.ack_level;
		cls_tick.sda_sense = in_item.sda_sense;
		unique case (in_item.opcode)
			i2cmbe_pkg::OP_START: cls_tick.cmd = i2cmbe_pkg::CMD_START;
			i2cmbe_pkg::OP_STOP:  cls_tick.cmd = i2cmbe_pkg::CMD_STOP;
			i2cmbe_pkg::OP_WRITE: cls_tick.cmd = i2cmbe_pkg::CMD_WRITE;
			i2cmbe_pkg::OP_READ:  cls_tick.cmd = i2cmbe_pkg::CMD_READ;
			i2cmbe_pkg::OP_TICK:  cls_tick.cmd = i2cmbe_pkg::CMD_NONE;
			// unused opcodes behave as a plain tick
			default:              cls_tick.cmd = i2cmbe_pkg::CMD_NONE;
		endcase
	end

	assign in_ready = (count_q != FULL_CNT);
	assign q_valid  = (count_q != '0);
	assign q_tick   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/i2cmbe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cmbe_back (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      cfg_we,
	input  wire  [i2cmbe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [i2cmbe_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  wire                                      q_valid,
	input  i2cmbe_pkg::tick_t                        q_tick,
	output logic                                     q_pop,
	output logic                                     out_valid,
	input  wire                                      out_ready,
	output i2cmbe_pkg::out_item_t                    out_item
);

	logic [7:0]         phase_ticks_q;
	logic [7:0]         read_tail_ticks_q;

	i2cmbe_pkg::phase_t phase_q,  phase_n;
	i2cmbe_pkg::cmd_t   active_q, active_n;
	logic [3:0]         bit_count_q, bit_count_n;
	logic [7:0]         shift_q, shift_n;
	logic [7:0]         wait_q, wait_n;
	logic               scl_q, scl_n;
	logic               sda_q, sda_n;
	logic               ack_q, ack_n;
	logic               nack_q, nack_n;

	logic               out_valid_q;
	i2cmbe_pkg::out_item_t out_q, res;

	logic [7:0] hold_len;
	logic [7:0] wait_dec;
	logic       is_cmd;
	logic       done;
	logic       dropped;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign hold_len = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;
	assign wait_dec = (wait_q != 8'd0) ? wait_q - 8'd1 : 8'd0;
	assign is_cmd   = (q_tick.cmd != i2cmbe_pkg::CMD_NONE);

	always_comb begin
		phase_n     = phase_q;
		active_n    = active_q;
		bit_count_n = bit_count_q;
		shift_n     = shift_q;
		wait_n      = wait_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		ack_n       = ack_q;
		nack_n      = nack_q;
		done        = 1'b0;
		dropped     = 1'b0;

		if (phase_q == i2cmbe_pkg::PH_IDLE) begin
			if (is_cmd) begin
				active_n    = q_tick.cmd;
				bit_count_n = 4'd0;
				wait_n      = hold_len;
				unique case (q_tick.cmd)
					i2cmbe_pkg::CMD_START: begin
						scl_n   = 1'b1;
						sda_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_ST_HIGH;
					end
					i2cmbe_pkg::CMD_STOP: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_SP_CLK;
					end
					i2cmbe_pkg::CMD_WRITE: begin
						shift_n = q_tick.data_byte;
						sda_n   = q_tick.data_byte[7];
						phase_n = i2cmbe_pkg::PH_WR_DATA;
					end
					default: begin
						shift_n = 8'd0;
						nack_n  = q_tick.ack_level;
						sda_n   = 1'b1;
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_RD_HIGH;
					end
				endcase
			end
		end else begin
			dropped = is_cmd;
			wait_n  = wait_dec;
			if (wait_dec == 8'd0) begin
				wait_n = hold_len;
				unique case (phase_q)
					i2cmbe_pkg::PH_ST_HIGH: begin
						sda_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_ST_LOW;
					end
					i2cmbe_pkg::PH_ST_LOW: begin
						scl_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_IDLE;
						wait_n  = 8'd0;
						done    = 1'b1;
					end
					i2cmbe_pkg::PH_SP_CLK: begin
						sda_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_SP_DAT;
					end
					i2cmbe_pkg::PH_WR_DATA: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_WR_HIGH;
					end
					i2cmbe_pkg::PH_WR_HIGH: begin
						scl_n       = 1'b0;
						shift_n     = {shift_q[6:0], 1'b0};
						bit_count_n = bit_count_q + 4'd1;
						phase_n     = i2cmbe_pkg::PH_WR_LOW;
					end
					i2cmbe_pkg::PH_WR_LOW: begin
						if (bit_count_q >= i2cmbe_pkg::BITS_PER_BYTE) begin
							sda_n   = 1'b1;
							phase_n = i2cmbe_pkg::PH_WR_REL;
						end else begin
							sda_n   = shift_q[7];
							phase_n = i2cmbe_pkg::PH_WR_DATA;
						end
					end
					i2cmbe_pkg::PH_WR_REL: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_WR_ACKH;
					end
					i2cmbe_pkg::PH_WR_ACKH: begin
						ack_n   = !q_tick.sda_sense;
						scl_n   = 1'b0;
						sda_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_IDLE;
						wait_n  = 8'd0;
						done    = 1'b1;
					end
					i2cmbe_pkg::PH_RD_HIGH: begin
						shift_n     = {shift_q[6:0], q_tick.sda_sense};
						scl_n       = 1'b0;
						bit_count_n = bit_count_q + 4'd1;
						phase_n     = i2cmbe_pkg::PH_RD_LOW;
					end
					i2cmbe_pkg::PH_RD_LOW: begin
						if (bit_count_q >= i2cmbe_pkg::BITS_PER_BYTE) begin
							sda_n   = nack_q;
							phase_n = i2cmbe_pkg::PH_RD_ACKS;
						end else begin
							scl_n   = 1'b1;
							phase_n = i2cmbe_pkg::PH_RD_HIGH;
						end
					end
					i2cmbe_pkg::PH_RD_ACKS: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_RD_ACKH;
					end
					i2cmbe_pkg::PH_RD_ACKH: begin
						scl_n = 1'b0;
						sda_n = 1'b0;
						if (read_tail_ticks_q == 8'd0) begin
							phase_n = i2cmbe_pkg::PH_IDLE;
							wait_n  = 8'd0;
							done    = 1'b1;
						end else begin
							phase_n = i2cmbe_pkg::PH_RD_TAIL;
							wait_n  = read_tail_ticks_q;
						end
					end
					// stop data phase, read tail and any stray code end the sequence
					default: begin
						phase_n = i2cmbe_pkg::PH_IDLE;
						wait_n  = 8'd0;
						done    = 1'b1;
					end
				endcase
			end
		end

		res.scl_level       = scl_n;
		res.sda_release     = sda_n;
		res.busy_res        = (phase_n != i2cmbe_pkg::PH_IDLE);
		res.done_res        = done;
		res.read_data       = (done && active_n == i2cmbe_pkg::CMD_READ) ? shift_n : 8'd0;
		res.slave_ack_low   = ack_n;
		res.command_dropped = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q     <= i2cmbe_pkg::PHASE_TICKS_RST;
			read_tail_ticks_q <= i2cmbe_pkg::READ_TAIL_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cmbe_pkg::CFG_PHASE_TICKS:     phase_ticks_q     <= cfg_wdata;
				i2cmbe_pkg::CFG_READ_TAIL_TICKS: read_tail_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cmbe_pkg::PH_IDLE;
			active_q    <= i2cmbe_pkg::CMD_NONE;
			bit_count_q <= 4'd0;
			shift_q     <= 8'd0;
			wait_q      <= 8'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			nack_q      <= 1'b0;
		end else if (q_pop) begin
			phase_q     <= phase_n;
			active_q    <= active_n;
			bit_count_q <= bit_count_n;
			shift_q     <= shift_n;
			wait_q      <= wait_n;
			scl_q       <= scl_n;
			sda_q       <= sda_n;
			ack_q       <= ack_n;
			nack_q      <= nack_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> rtl/i2c_master_byte_engine_unit.sv
// path: an accepted tick passes through the queue, then the sequencer's output register
// throughput: one tick per cycle unless the output stalls; the sequencer updates all bus
// state per tick and pops the queue whenever its output register is empty or being taken
// reset: arst_n clears the queue and output register, returns the bus to idle with
// both lines released, and loads phase_ticks = 5 and read_tail_ticks = 3
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  i2cmbe_pkg::in_item_t              in_item,
	output logic                              out_valid,
	input  wire                               out_ready,
	output i2cmbe_pkg::out_item_t             out_item,
	input  wire                               cfg_we,
	input  wire  [i2cmbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [i2cmbe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic              q_valid;
	logic              q_pop;
	i2cmbe_pkg::tick_t q_tick;

	i2cmbe_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_tick   (q_tick),
		.q_pop    (q_pop)
	);

	i2cmbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_tick    (q_tick),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

>>> rtl/i2cmbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cmbe_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        out_valid,
	input wire                        out_ready,
	input i2cmbe_pkg::out_item_t      out_item
);

	// a stalled result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output changed while stalled");

	// a finishing tick leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.done_res |-> !out_item.busy_res)
		else $error("done reported while still busy");

	// received byte only shows on the finishing tick
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.done_res |-> out_item.read_data == 8'd0)
		else $error("read data outside done tick");

	// after a finishing tick, the next result never reports done while still busy
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.done_res ##1 out_valid
			|-> !(out_item.done_res && out_item.busy_res))
		else $error("done pulse with busy after finish");

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

`default_nettype wire
